// File: rtl/core/lmvs_pkg.sv
// Package for the low memory victim selector: field widths, request codes,
// controller states and the command, status and configuration structs.
// Depends on nothing; every other file of the block imports it.
package lmvs_pkg;

  localparam int unsigned PID_W       = 16;
  localparam int unsigned SCORE_W     = 11;
  localparam int unsigned SIZE_W      = 24;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned CFG_W       = 59;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MAX_RESULTS = 16;

  // Reported when no level is reached or the request is not a report.
  localparam logic [LEVEL_W-1:0] NO_LEVEL = 3'd4;

  // Index of the minimum-block register on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK = 3'd4;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_LAUNCH = 2'd3
  } lmvs_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } lmvs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request
    logic pass_start;  // clear the scan accumulators, latch the level
    logic read_en;     // read the table entry at the scan address
    logic apply;       // update the table and drive one result beat
  } lmvs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_scan;   // request needs no table scan
    logic more;        // report has further victims to emit
  } lmvs_status_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } lmvs_cfg_wr_t;

endpackage

// File: rtl/core/lmvs_ctrl.sv
// Controller of the low memory victim selector: request sequencing state
// machine and the table scan address counter. Depends on lmvs_pkg.
module lmvs_ctrl import lmvs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  lmvs_status_t                   status_i,
  output lmvs_cmd_t                      cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] addr_o,
  output logic                           busy_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  lmvs_state_e   state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.pass_start = 1'b1;
        addr_d           = '0;
        state_d          = status_i.skip_scan ? ST_APPLY : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.read_en = 1'b1;
        addr_d        = addr_q + AW'(1);
        if (addr_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry read is evaluated in this cycle.
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        if (status_i.more) begin
          cmd_o.pass_start = 1'b1;
          addr_d           = '0;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign addr_o = addr_q;

endmodule

// File: rtl/core/lmvs_datapath.sv
// Datapath of the low memory victim selector: configuration registers,
// process table memory, scan evaluation and the result register.
// Depends on lmvs_pkg; driven by lmvs_ctrl.
module lmvs_datapath import lmvs_pkg::*; #(
  parameter int unsigned LEVEL_COUNT = 4,
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lmvs_cfg_wr_t                   cfg_i,
  input  lmvs_cmd_t                      cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] addr_i,
  output lmvs_status_t                   status_o,
  input  logic [1:0]                     req_type_i,
  input  logic [PID_W-1:0]               proc_id_i,
  input  logic signed [SCORE_W-1:0]      kill_score_i,
  input  logic [SIZE_W-1:0]              free_bytes_i,
  input  logic [SIZE_W-1:0]              largest_block_i,
  output logic                           result_valid_o,
  output logic                           victim_valid_o,
  output logic [PID_W-1:0]               victim_pid_o,
  output logic [LEVEL_W-1:0]             level_hit_o,
  output logic                           launch_ok_o,
  output logic                           res_status_o,
  output logic                           last_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  // Configuration.
  logic [CFG_W-1:0]  lvl_cfg_q [LEVEL_COUNT];
  logic [SIZE_W-1:0] min_block_q;

  // Request.
  lmvs_req_e                req_q;
  logic [PID_W-1:0]         pid_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [SIZE_W-1:0]        free_q;
  logic [SIZE_W-1:0]        block_q;
  logic [LEVEL_W-1:0]       lvl_hit_q;
  logic signed [SCORE_W-1:0] limit_q;
  logic [NW-1:0]            n_q;

  // Table.
  logic [TABLE_DEPTH-1:0]    valid_q;
  logic [PID_W-1:0]          pid_mem   [TABLE_DEPTH];
  logic [SCORE_W-1:0]        score_mem [TABLE_DEPTH];
  logic                      rd_en_q;
  logic [AW-1:0]             rd_idx_q;
  logic [PID_W-1:0]          rd_pid_q;
  logic signed [SCORE_W-1:0] rd_score_q;

  // Scan accumulators.
  logic          match_found_q, free_found_q, best_found_q;
  logic [AW-1:0] match_idx_q, free_idx_q, best_idx_q;
  logic [PID_W-1:0] best_pid_q;
  logic [CW-1:0] cnt_q;

  // Result register.
  logic               res_valid_q;
  logic               res_victim_q;
  logic [PID_W-1:0]   res_pid_q;
  logic [LEVEL_W-1:0] res_level_q;
  logic               res_ok_q;
  logic               res_full_q;
  logic               res_last_q;

  logic                      lvl_hit;
  logic [LEVEL_W-1:0]        lvl_idx;
  logic signed [SCORE_W-1:0] lvl_limit;
  logic                      samp_v, is_match, is_free, is_cand, is_better;
  logic                      slot_ok;
  logic [AW-1:0]             slot_idx;
  logic                      more;

  // First level whose free or block limit is reached.
  always_comb begin
    lvl_hit   = 1'b0;
    lvl_idx   = NO_LEVEL;
    lvl_limit = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (free_q <= lvl_cfg_q[i][SIZE_W-1:0] ||
          block_q <= lvl_cfg_q[i][2*SIZE_W-1:SIZE_W]) begin
        lvl_hit   = 1'b1;
        lvl_idx   = LEVEL_W'(i);
        lvl_limit = lvl_cfg_q[i][CFG_W-1:2*SIZE_W];
      end
    end
  end

  assign samp_v    = valid_q[rd_idx_q];
  assign is_match  = samp_v && (rd_pid_q == pid_q);
  assign is_free   = !samp_v;
  assign is_cand   = samp_v && (rd_score_q >= limit_q);
  assign is_better = is_cand && (!best_found_q || rd_pid_q < best_pid_q);

  assign slot_ok  = match_found_q || free_found_q;
  assign slot_idx = match_found_q ? match_idx_q : free_idx_q;

  // Another victim follows if more than one candidate remained in this pass
  // and the per-report limit is not reached.
  assign more = (req_q == REQ_REPORT) && best_found_q && (cnt_q > CW'(1)) &&
                (n_q < NW'(MAX_RESULTS - 1));

  assign status_o.skip_scan = (req_q == REQ_LAUNCH) ||
                              ((req_q == REQ_REPORT) && !lvl_hit);
  assign status_o.more      = more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        lvl_cfg_q[i] <= '0;
      end
      min_block_q <= '0;
    end else if (cfg_i.we) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        if (cfg_i.idx == CFG_IDX_W'(i)) begin
          lvl_cfg_q[i] <= cfg_i.data;
        end
      end
      if (cfg_i.idx == CFG_MIN_BLOCK) begin
        min_block_q <= cfg_i.data[SIZE_W-1:0];
      end
    end
  end

  // Request payload and pass constants.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= lmvs_req_e'(req_type_i);
      pid_q   <= proc_id_i;
      score_q <= kill_score_i;
      free_q  <= free_bytes_i;
      block_q <= largest_block_i;
    end
    if (cmd_i.pass_start) begin
      lvl_hit_q <= lvl_idx;
      limit_q   <= lvl_limit;
    end
  end

  // Table memory: one read and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && req_q == REQ_SET && slot_ok) begin
      pid_mem[slot_idx]   <= pid_q;
      score_mem[slot_idx] <= score_q;
    end
    if (cmd_i.read_en) begin
      rd_pid_q   <= pid_mem[addr_i];
      rd_score_q <= score_mem[addr_i];
      rd_idx_q   <= addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      rd_en_q       <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
      cnt_q         <= '0;
      n_q           <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      rd_en_q     <= cmd_i.read_en;
      res_valid_q <= cmd_i.apply;
      if (cmd_i.load) begin
        n_q <= '0;
      end
      if (cmd_i.apply) begin
        case (req_q)
          REQ_SET: begin
            if (slot_ok) begin
              valid_q[slot_idx] <= 1'b1;
            end
          end
          REQ_CANCEL: begin
            if (match_found_q) begin
              valid_q[match_idx_q] <= 1'b0;
            end
          end
          REQ_REPORT: begin
            if (best_found_q) begin
              valid_q[best_idx_q] <= 1'b0;
              n_q                 <= n_q + NW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.pass_start) begin
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        best_found_q  <= 1'b0;
        cnt_q         <= '0;
      end else if (rd_en_q) begin
        if (is_match) begin
          match_found_q <= 1'b1;
        end
        if (is_free && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        if (is_better) begin
          best_found_q <= 1'b1;
        end
        if (is_cand) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  // Scan accumulator payload.
  always_ff @(posedge clk_i) begin
    if (rd_en_q && !cmd_i.pass_start) begin
      if (is_match) begin
        match_idx_q <= rd_idx_q;
      end
      if (is_free && !free_found_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (is_better) begin
        best_idx_q <= rd_idx_q;
        best_pid_q <= rd_pid_q;
      end
    end
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_victim_q <= 1'b0;
      res_pid_q    <= '0;
      res_level_q  <= NO_LEVEL;
      res_ok_q     <= 1'b0;
      res_full_q   <= 1'b0;
      res_last_q   <= 1'b1;
      case (req_q)
        REQ_SET: begin
          res_full_q <= !slot_ok;
        end
        REQ_LAUNCH: begin
          res_ok_q <= (block_q >= min_block_q);
        end
        REQ_REPORT: begin
          res_level_q <= lvl_hit_q;
          if (best_found_q) begin
            res_victim_q <= 1'b1;
            res_pid_q    <= best_pid_q;
            res_last_q   <= !more;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign victim_valid_o = res_victim_q;
  assign victim_pid_o   = res_pid_q;
  assign level_hit_o    = res_level_q;
  assign launch_ok_o    = res_ok_q;
  assign res_status_o   = res_full_q;
  assign last_o         = res_last_q;

endmodule

// File: rtl/core/low_memory_victim_selector_unit.sv
// Top level of the low memory victim selector: joins the controller and the
// datapath. Depends on lmvs_pkg, lmvs_ctrl and lmvs_datapath.
//
//   Channel   Handshake                       Payload
//   request   start_i accepted when !busy_o   req_type_i, proc_id_i,
//                                             kill_score_i, free_bytes_i,
//                                             largest_block_i
//   result    result_valid_o, one cycle       victim_valid_o, victim_pid_o,
//                                             level_hit_o, launch_ok_o,
//                                             status_o, last_o
//   config    cfg_we_i, no wait               cfg_idx_i, cfg_data_i
//
// A set or cancel request scans the whole table through its single read
// port before its result beat appears. A launch check, or a report that
// reaches no level, skips the scan. A report repeats one full table scan
// per victim, with one result beat per scan; busy_o falls in the cycle of
// the final beat. Reset empties the table at once through its valid
// flip-flops and clears all configuration registers. The receiver cannot
// stall, so every result beat is presented for exactly one cycle.
module low_memory_victim_selector_unit import lmvs_pkg::*; #(
  parameter int unsigned LEVEL_COUNT = 4,
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                req_type_i,
  input  logic [PID_W-1:0]          proc_id_i,
  input  logic signed [SCORE_W-1:0] kill_score_i,
  input  logic [SIZE_W-1:0]         free_bytes_i,
  input  logic [SIZE_W-1:0]         largest_block_i,
  output logic                      result_valid_o,
  output logic                      victim_valid_o,
  output logic [PID_W-1:0]          victim_pid_o,
  output logic [LEVEL_W-1:0]        level_hit_o,
  output logic                      launch_ok_o,
  output logic                      status_o,
  output logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  lmvs_cmd_t     cmd;
  lmvs_status_t  dp_status;
  lmvs_cfg_wr_t  cfg_wr;
  logic [AW-1:0] scan_addr;

  // Configuration writes go unchecked to the datapath; the user must issue
  // them only while the block is idle, so no scan sees a half-changed level.
  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  lmvs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(dp_status),
    .cmd_o   (cmd),
    .addr_o  (scan_addr),
    .busy_o  (busy_o)
  );

  // The datapath holds the table; victims are found by a minimum-pid search
  // over one full scan, so they leave in ascending pid order.
  lmvs_datapath #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_wr),
    .cmd_i          (cmd),
    .addr_i         (scan_addr),
    .status_o       (dp_status),
    .req_type_i     (req_type_i),
    .proc_id_i      (proc_id_i),
    .kill_score_i   (kill_score_i),
    .free_bytes_i   (free_bytes_i),
    .largest_block_i(largest_block_i),
    .result_valid_o (result_valid_o),
    .victim_valid_o (victim_valid_o),
    .victim_pid_o   (victim_pid_o),
    .level_hit_o    (level_hit_o),
    .launch_ok_o    (launch_ok_o),
    .res_status_o   (status_o),
    .last_o         (last_o)
  );

endmodule

// File: test/low_memory_victim_selector_unit_tb.sv
// Self-checking testbench for low_memory_victim_selector_unit: directed rows, then random
// requests under several threshold settings, every result beat checked against a local
// table model or a typed beat. Depends on lmvs_pkg and the block's RTL; reads no files.
module low_memory_victim_selector_unit_tb import lmvs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS = 4;
  localparam int unsigned DEPTH = 16;
  localparam int unsigned POOL_SIZE = 20;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0 = 3'd0;

  // One result beat as it appears on the output ports.
  typedef struct packed {
    logic               victim;
    logic [PID_W-1:0]   pid;
    logic [LEVEL_W-1:0] level;
    logic               ok;
    logic               status;
    logic               last;
  } result_beat_t;

  // A directed request; reps repeats it with the pid counting up. Where typed is set, the
  // single beat in want is awaited instead of the model's answer.
  typedef struct packed {
    lmvs_req_e                 req;
    logic [PID_W-1:0]          pid;
    logic signed [SCORE_W-1:0] score;
    logic [SIZE_W-1:0]         free_sz;
    logic [SIZE_W-1:0]         block_sz;
    logic [4:0]                reps;
    logic                      typed;
    result_beat_t              want;
  } plan_row_t;

  // Single-beat answers that can be written down without working anything out.
  localparam result_beat_t DONE_BEAT = '{1'b0, 16'h0, NO_LEVEL, 1'b0, 1'b0, 1'b1};
  localparam result_beat_t LAUNCH_OK = '{1'b0, 16'h0, NO_LEVEL, 1'b1, 1'b0, 1'b1};
  localparam result_beat_t FULL_BEAT = '{1'b0, 16'h0, NO_LEVEL, 1'b0, 1'b1, 1'b1};

  localparam int unsigned PLAN_ROWS = 14;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Thresholds are all zero here, so any block size passes a launch check.
    '{REQ_LAUNCH, 16'h0000, 11'sd0, 24'h000000, 24'h000000, 5'd1, 1'b1, LAUNCH_OK},
    '{REQ_LAUNCH, 16'hffff, 11'h400, 24'hffffff, 24'hffffff, 5'd1, 1'b1, LAUNCH_OK},
    // A report of one byte reaches no level while every limit is zero.
    '{REQ_REPORT, 16'h0000, 11'sd1023, 24'h000001, 24'h000001, 5'd1, 1'b1, DONE_BEAT},
    // Cancelling a pid that is not in the table changes nothing.
    '{REQ_CANCEL, 16'h1234, 11'sd0, 24'h000000, 24'h000000, 5'd1, 1'b1, DONE_BEAT},
    '{REQ_SET, 16'h0000, 11'sd1023, 24'h000000, 24'h000000, 5'd1, 1'b1, DONE_BEAT},
    '{REQ_SET, 16'hffff, 11'h400, 24'h000000, 24'h000000, 5'd1, 1'b1, DONE_BEAT},
    // Update of a pid already present.
    '{REQ_SET, 16'h0000, -11'sd5, 24'h000000, 24'h000000, 5'd1, 1'b1, DONE_BEAT},
    // Fourteen new pids fill the remaining slots.
    '{REQ_SET, 16'h8000, 11'sd0, 24'h000000, 24'h000000, 5'd14, 1'b1, DONE_BEAT},
    // A new pid with the table full is dropped with status set.
    '{REQ_SET, 16'h1234, 11'sd7, 24'h000000, 24'h000000, 5'd1, 1'b1, FULL_BEAT},
    // An update still goes through with the table full.
    '{REQ_SET, 16'hffff, 11'sd0, 24'h000000, 24'h000000, 5'd1, 1'b1, DONE_BEAT},
    // Reports reaching level 0, first on free memory and then on the largest block.
    '{REQ_REPORT, 16'h0000, 11'sd0, 24'h000000, 24'hffffff, 5'd1, 1'b0, '0},
    '{REQ_REPORT, 16'h0000, 11'sd0, 24'hffffff, 24'h000000, 5'd1, 1'b0, '0},
    '{REQ_CANCEL, 16'h0000, 11'sd0, 24'h000000, 24'h000000, 5'd1, 1'b1, DONE_BEAT},
    '{REQ_REPORT, 16'hffff, 11'sd1023, 24'h000000, 24'h000000, 5'd1, 1'b0, '0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [1:0]                req_type_i;
  logic [PID_W-1:0]          proc_id_i;
  logic signed [SCORE_W-1:0] kill_score_i;
  logic [SIZE_W-1:0]         free_bytes_i;
  logic [SIZE_W-1:0]         largest_block_i;
  logic                      result_valid_o;
  logic                      victim_valid_o;
  logic [PID_W-1:0]          victim_pid_o;
  logic [LEVEL_W-1:0]        level_hit_o;
  logic                      launch_ok_o;
  logic                      status_o;
  logic                      last_o;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_W-1:0]          cfg_data_i;

  // Local copy of the process table and the threshold registers.
  logic                      slot_used [DEPTH];
  logic [PID_W-1:0]          slot_pid [DEPTH];
  logic signed [SCORE_W-1:0] slot_score [DEPTH];
  logic [CFG_W-1:0]          level_cfg [LEVELS];
  logic [SIZE_W-1:0]         min_block;

  result_beat_t model_beats[$];    // answer of the model to the request just accepted
  result_beat_t awaited_beats[$];  // beats still owed by the block, oldest first

  // Set by the driver together with the request, read when the request is accepted.
  logic         row_typed;
  result_beat_t row_want;

  logic [PID_W-1:0] pid_pool [POOL_SIZE];
  int mismatches = 0;
  int stall_cycles = 0;

  low_memory_victim_selector_unit #(
    .LEVEL_COUNT(LEVELS),
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .proc_id_i      (proc_id_i),
    .kill_score_i   (kill_score_i),
    .free_bytes_i   (free_bytes_i),
    .largest_block_i(largest_block_i),
    .result_valid_o (result_valid_o),
    .victim_valid_o (victim_valid_o),
    .victim_pid_o   (victim_pid_o),
    .level_hit_o    (level_hit_o),
    .launch_ok_o    (launch_ok_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int find_slot(logic [PID_W-1:0] pid);
    int hit;
    hit = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit < 0 && slot_used[i] && slot_pid[i] == pid) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  function automatic result_beat_t plain_beat(logic ok, logic status);
    return '{1'b0, '0, NO_LEVEL, ok, status, 1'b1};
  endfunction

  // Works out the beats that a request causes and applies it to the local table. A report
  // takes the first level reached, then removes matching entries lowest pid first.
  task automatic compute_victim_beats(input lmvs_req_e req, input logic [PID_W-1:0] pid,
                                      input logic signed [SCORE_W-1:0] score,
                                      input logic [SIZE_W-1:0] free_sz,
                                      input logic [SIZE_W-1:0] block_sz);
    int slot;
    int best;
    int victims;
    logic [LEVEL_W-1:0] level;
    logic signed [SCORE_W-1:0] limit;
    result_beat_t beat;
    slot = -1;
    victims = 0;
    level = NO_LEVEL;
    limit = '0;
    model_beats.delete();
    case (req)
      REQ_SET: begin
        slot = find_slot(pid);
        for (int i = 0; i < DEPTH; i++) begin
          if (slot < 0 && !slot_used[i]) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          model_beats.insert(model_beats.size(), plain_beat(1'b0, 1'b1));
        end else begin
          slot_used[slot] = 1'b1;
          slot_pid[slot] = pid;
          slot_score[slot] = score;
          model_beats.insert(model_beats.size(), plain_beat(1'b0, 1'b0));
        end
      end
      REQ_CANCEL: begin
        slot = find_slot(pid);
        if (slot >= 0) begin
          slot_used[slot] = 1'b0;
        end
        model_beats.insert(model_beats.size(), plain_beat(1'b0, 1'b0));
      end
      REQ_LAUNCH: begin
        model_beats.insert(model_beats.size(), plain_beat(block_sz >= min_block, 1'b0));
      end
      default: begin
        for (int i = 0; i < LEVELS; i++) begin
          if (level == NO_LEVEL && (free_sz <= level_cfg[i][23:0] ||
                                    block_sz <= level_cfg[i][47:24])) begin
            level = LEVEL_W'(i);
            limit = level_cfg[i][58:48];
          end
        end
        if (level != NO_LEVEL) begin
          while (victims < int'(MAX_RESULTS)) begin
            best = -1;
            for (int i = 0; i < DEPTH; i++) begin
              if (slot_used[i] && slot_score[i] >= limit &&
                  (best < 0 || slot_pid[i] < slot_pid[best])) begin
                best = i;
              end
            end
            if (best < 0) break;
            slot_used[best] = 1'b0;
            beat = '{1'b1, slot_pid[best], level, 1'b0, 1'b0, 1'b0};
            model_beats.insert(model_beats.size(), beat);
            victims++;
          end
        end
        if (victims == 0) begin
          beat = '{1'b0, '0, level, 1'b0, 1'b0, 1'b1};
          model_beats.insert(model_beats.size(), beat);
        end else begin
          model_beats[victims-1].last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Everything is sampled on the rising edge, where the block's outputs still hold their
  // values from before the edge. A result beat is checked first, then a request accepted at
  // the same edge is predicted; the two can never belong to the same request.
  always @(posedge clk_i) begin
    result_beat_t seen;
    result_beat_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        seen = '{victim_valid_o, victim_pid_o, level_hit_o, launch_ok_o, status_o, last_o};
        if (awaited_beats.size() == 0) begin
          $display("%0t: result beat with nothing awaited, expected none, actual %p",
                   $time, seen);
          mismatches++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("victim_valid", 16'(seen.victim), 16'(want.victim));
          check_field("victim_pid", seen.pid, want.pid);
          check_field("level_hit", 16'(seen.level), 16'(want.level));
          check_field("launch_ok", 16'(seen.ok), 16'(want.ok));
          check_field("status", 16'(seen.status), 16'(want.status));
          check_field("last", 16'(seen.last), 16'(want.last));
        end
      end
      if (start_i && !busy_o) begin
        // The model always runs so that the local table follows the block, even where the
        // answer of a directed row has been written down by hand.
        compute_victim_beats(lmvs_req_e'(req_type_i), proc_id_i, kill_score_i,
                             free_bytes_i, largest_block_i);
        if (row_typed) begin
          awaited_beats.insert(awaited_beats.size(), row_want);
        end else begin
          foreach (model_beats[i]) awaited_beats.insert(awaited_beats.size(), model_beats[i]);
        end
      end
    end
  end

  // Watchdog: a stretch without a request or a result beat that reaches STALL_LIMIT
  // means the block has hung or lost a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("low_memory_victim_selector_unit test failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request was accepted,
  // with start_i still high so that the caller may present the next request straight away.
  task automatic send_request(input lmvs_req_e req, input logic [PID_W-1:0] pid,
                              input logic signed [SCORE_W-1:0] score,
                              input logic [SIZE_W-1:0] free_sz,
                              input logic [SIZE_W-1:0] block_sz,
                              input logic typed, input result_beat_t want);
    req_type_i <= req;
    proc_id_i <= pid;
    kill_score_i <= score;
    free_bytes_i <= free_sz;
    largest_block_i <= block_sz;
    start_i <= 1'b1;
    row_typed = typed;
    row_want = want;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Holds requests back until every awaited beat has arrived and the block is idle.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (awaited_beats.size() != 0 || busy_o);
  endtask

  // Writes all four level registers and the minimum block size, one per cycle.
  task automatic program_thresholds(input logic [CFG_W-1:0] l0, input logic [CFG_W-1:0] l1,
                                    input logic [CFG_W-1:0] l2, input logic [CFG_W-1:0] l3,
                                    input logic [SIZE_W-1:0] min_sz);
    logic [CFG_W-1:0] levels [LEVELS];
    levels = '{l0, l1, l2, l3};
    for (int i = 0; i < LEVELS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_LEVEL0 + CFG_IDX_W'(i);
      cfg_data_i <= levels[i];
      level_cfg[i] = levels[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MIN_BLOCK;
    cfg_data_i <= CFG_W'(min_sz);
    min_block = min_sz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pack_level(logic signed [SCORE_W-1:0] score_lim,
                                                 logic [SIZE_W-1:0] block_lim,
                                                 logic [SIZE_W-1:0] free_lim);
    return {score_lim, block_lim, free_lim};
  endfunction

  // Sizes lean towards the ends of the range and towards the limits used below.
  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return SIZE_W'($urandom_range(0, 'hfff));
      3: return SIZE_W'($urandom_range(0, 'hfffff));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // Set requests lead, on a small pool of pids, so the table fills up, gets updated
  // and is emptied by reports; a few pids come from the whole range as noise.
  task automatic run_random(input int count, input logic idling);
    lmvs_req_e req;
    logic [PID_W-1:0] pid;
    logic signed [SCORE_W-1:0] score;
    int pick;
    for (int k = 0; k < count; k++) begin
      if (idling && $urandom_range(0, 3) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      // Once per idling phase the sender waits for the block to go fully quiet.
      if (idling && k == count / 2) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      req = pick < 45 ? REQ_SET : pick < 65 ? REQ_CANCEL : pick < 85 ? REQ_REPORT : REQ_LAUNCH;
      pid = $urandom_range(0, 99) < 85 ? pid_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : PID_W'($urandom);
      case ($urandom_range(0, 9))
        0: score = 11'h400;
        1: score = 11'sd1023;
        default: score = SCORE_W'($urandom);
      endcase
      send_request(req, pid, score, rand_size(), rand_size(), 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_type_i = REQ_SET;
    proc_id_i = '0;
    kill_score_i = '0;
    free_bytes_i = '0;
    largest_block_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LEVEL0;
    cfg_data_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_pid[i] = '0;
      slot_score[i] = '0;
    end
    for (int i = 0; i < LEVELS; i++) level_cfg[i] = '0;
    min_block = '0;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pid_pool[i] = PID_W'($urandom);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows run with the thresholds as left by reset.
    for (int row = 0; row < PLAN_ROWS; row++) begin
      for (int r = 0; r < PLAN[row].reps; r++) begin
        send_request(PLAN[row].req, PLAN[row].pid + PID_W'(r), PLAN[row].score,
                     PLAN[row].free_sz, PLAN[row].block_sz, PLAN[row].typed, PLAN[row].want);
      end
    end

    // Graded levels: each reached at a larger size and killing down to a lower score.
    wait_drained();
    program_thresholds(pack_level(11'sd800, 24'h000100, 24'h001000),
                       pack_level(11'sd400, 24'h001000, 24'h010000),
                       pack_level(11'sd0, 24'h010000, 24'h100000),
                       pack_level(11'h400, 24'h100000, 24'h800000), 24'h008000);
    run_random(35, 1'b1);

    // Extremes: level 0 only on a report of zero and only for the top score, level 1 on
    // everything else taking the whole table; launches refused below the largest size.
    wait_drained();
    program_thresholds(pack_level(11'sd1023, 24'h000000, 24'h000000),
                       pack_level(11'h400, 24'hffffff, 24'hffffff), '1, '0, 24'hffffff);
    run_random(35, 1'b1);

    wait_drained();
    program_thresholds(pack_level(SCORE_W'($urandom), rand_size(), rand_size()),
                       pack_level(SCORE_W'($urandom), rand_size(), rand_size()),
                       pack_level(SCORE_W'($urandom), rand_size(), rand_size()),
                       pack_level(SCORE_W'($urandom), rand_size(), rand_size()), rand_size());
    run_random(35, 1'b1);

    // Last stretch back to back, with no gaps from the sender.
    wait_drained();
    program_thresholds(pack_level(SCORE_W'($urandom), rand_size(), rand_size()),
                       pack_level(SCORE_W'($urandom), rand_size(), rand_size()),
                       pack_level(SCORE_W'($urandom), rand_size(), rand_size()),
                       pack_level(SCORE_W'($urandom), rand_size(), rand_size()), rand_size());
    run_random(28, 1'b0);

    wait_drained();
    repeat (DEPTH + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("low_memory_victim_selector_unit test passed");
    end else begin
      $display("low_memory_victim_selector_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/lmvs_pkg.sv
rtl/core/lmvs_ctrl.sv
rtl/core/lmvs_datapath.sv
rtl/core/low_memory_victim_selector_unit.sv
test/low_memory_victim_selector_unit_tb.sv
